### rtl/md5_pkg.sv
// md5_pkg: shared types, constants and round tables of the MD5 digest block.
// No dependencies; the RTL modules and the testbench import it.
package md5_pkg;

   // Initial chaining words, index 0 is word A
   localparam logic [3:0][31:0] MD5_INIT = {32'h10325476, 32'h98badcfe,
                                            32'hefcdab89, 32'h67452301};

   localparam logic [7:0] MD5_PAD_BYTE   = 8'h80;
   localparam logic [5:0] MD5_LAST_POS   = 6'd63;
   localparam logic [5:0] MD5_LEN_POS    = 6'd56;
   localparam logic [5:0] MD5_LAST_ROUND = 6'd63;
   localparam logic [1:0] MD5_LAST_WORD  = 2'd3;
   localparam logic [63:0] MD5_BITS_PER_BYTE = 64'd8;

   // Block queue depth (power of two)
   localparam int MD5_Q_DEPTH = 2;
   localparam int MD5_Q_PTR_W = $clog2(MD5_Q_DEPTH);
   localparam int MD5_Q_CNT_W = $clog2(MD5_Q_DEPTH + 1);

   // One 64-byte block: byte k sits at bits 8k+7..8k, word w at bits 32w+31..32w
   typedef logic [63:0][7:0]  md5_bytes_type;
   typedef logic [15:0][31:0] md5_words_type;

   // One queued block; last_blk closes a message
   typedef struct packed {
      logic          last_blk;
      md5_words_type words;
   } md5_blk_type;

   typedef struct packed {
      logic full;
      logic empty;
   } md5_q_status_type;

   // Additive constant of each round
   function automatic logic [31:0] md5_k(input logic [5:0] r);
      logic [31:0] k;
      begin
         case (r)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
         endcase
         return k;
      end
   endfunction

   // Rotate amount of each round
   function automatic logic [4:0] md5_shift(input logic [5:0] r);
      logic [4:0] s;
      begin
         case ({r[5:4], r[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
         endcase
         return s;
      end
   endfunction

   // Message word used by each round
   function automatic logic [3:0] md5_g(input logic [5:0] r);
      logic [3:0] r4;
      logic [3:0] g;
      begin
         r4 = r[3:0];
         case (r[5:4])
            2'd0:    g = r4;
            2'd1:    g = r4 * 4'd5 + 4'd1;
            2'd2:    g = r4 * 4'd3 + 4'd5;
            default: g = r4 * 4'd7;
         endcase
         return g;
      end
   endfunction

   // Round function of each group of sixteen rounds
   function automatic logic [31:0] md5_f(input logic [1:0] grp, input logic [31:0] b,
                                         input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      begin
         case (grp)
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & d) | (c & ~d);
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
         endcase
         return f;
      end
   endfunction

   function automatic logic [31:0] md5_rotl(input logic [31:0] x, input logic [4:0] s);
      logic [63:0] dbl;
      begin
         dbl = {x, x} << s;
         return dbl[63:32];
      end
   endfunction

endpackage

### rtl/md5_req_if.sv
// md5_req_if: message byte channel, valid/ready handshake.
// No dependencies.
interface md5_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       last_byte;

   modport source (output valid, data_byte, byte_valid, last_byte, input ready);
   modport sink   (input valid, data_byte, byte_valid, last_byte, output ready);
endinterface

### rtl/md5_rsp_if.sv
// md5_rsp_if: digest word channel, valid/ready handshake.
// No dependencies.
interface md5_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [1:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

### rtl/md5_message_digest.sv
// MD5 message digest, top level: byte front, block queue and round engine.
// Depends on md5_pkg, md5_req_if, md5_rsp_if and the three submodules.
//
// Takes one message byte per word on req_chan (byte_valid marks a real byte,
// last_byte ends the message; a last word without a byte is allowed) and
// returns the 128-bit digest as four words A..D on rsp_chan, low byte first,
// last_word set on D. Bytes are accepted one per cycle while the two-entry
// block queue has room and no padding block is pending. The round engine
// works through each 64-byte block in turn (load, setup, 64 rounds at one per
// cycle, feed-forward add), so sustained throughput is set by that single
// round unit. A message end adds one or two padding blocks and holds the
// byte input while they are queued, and the digest follows as four words
// once the final block is done. Afterwards the block starts a new message
// from the initial chaining values.
module md5_message_digest
   import md5_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   md5_req_if.sink    req_chan,
   md5_rsp_if.source  rsp_chan
);

   logic             push_valid;
   md5_blk_type      push_entry;
   logic             pop;
   md5_blk_type      pop_entry;
   md5_q_status_type q_status;

   md5_msg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .q_status   (q_status)
   );

   md5_blk_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .q_status   (q_status)
   );

   md5_round_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

### rtl/md5_msg_front.sv
// md5_msg_front: gathers message bytes into blocks, pads the message end and
// pushes finished blocks into the block queue. Depends on md5_pkg, md5_req_if.
module md5_msg_front
   import md5_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   md5_req_if.sink          req_chan,
   output logic             push_valid,
   output md5_blk_type      push_entry,
   input  md5_q_status_type q_status
);

   typedef enum logic [1:0] {ST_COLLECT, ST_PAD, ST_LEN} state_type;

   state_type     state_ff, state_in;
   logic [63:0]   bits_ff, bits_in;
   md5_bytes_type block_ff, block_in;

   logic          accept;
   logic [5:0]    pos;
   md5_bytes_type merged;
   md5_bytes_type padded;
   md5_words_type padded_words;
   md5_words_type len_words;

   assign req_chan.ready = (state_ff == ST_COLLECT) && !q_status.full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign pos            = bits_ff[8:3];

   // Block with the incoming byte written at the fill position
   always_comb begin
      merged      = block_ff;
      merged[pos] = req_chan.data_byte;
   end

   // Pad byte after the message, zeros beyond it
   always_comb begin
      for (int k = 0; k < 64; k++) begin
         if (6'(k) < pos) begin
            padded[k] = block_ff[k];
         end else if (6'(k) == pos) begin
            padded[k] = MD5_PAD_BYTE;
         end else begin
            padded[k] = 8'h00;
         end
      end
      padded_words = md5_words_type'(padded);
      len_words    = '0;
      len_words[14] = bits_ff[31:0];
      len_words[15] = bits_ff[63:32];
   end

   // Fill, pad and push control
   always_comb begin
      state_in   = state_ff;
      bits_in    = bits_ff;
      block_in   = block_ff;
      push_valid = 1'b0;
      push_entry = '{last_blk: 1'b0, words: md5_words_type'(merged)};
      unique case (state_ff)
         ST_COLLECT: begin
            if (accept) begin
               if (req_chan.byte_valid) begin
                  block_in = merged;
                  bits_in  = bits_ff + MD5_BITS_PER_BYTE;
                  push_valid = (pos == MD5_LAST_POS);
               end
               if (req_chan.last_byte) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (!q_status.full) begin
               push_valid = 1'b1;
               push_entry.words = padded_words;
               if (pos < MD5_LEN_POS) begin
                  push_entry.words[14] = bits_ff[31:0];
                  push_entry.words[15] = bits_ff[63:32];
                  push_entry.last_blk  = 1'b1;
                  bits_in  = '0;
                  state_in = ST_COLLECT;
               end else begin
                  state_in = ST_LEN;
               end
            end
         end
         ST_LEN: begin
            if (!q_status.full) begin
               push_valid = 1'b1;
               push_entry = '{last_blk: 1'b1, words: len_words};
               bits_in    = '0;
               state_in   = ST_COLLECT;
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         bits_ff  <= '0;
      end else begin
         state_ff <= state_in;
         bits_ff  <= bits_in;
      end
   end

   // Block buffer, no reset: every byte is written before it is used
   always_ff @(posedge clock) begin
      block_ff <= block_in;
   end

endmodule

### rtl/md5_blk_queue.sv
// md5_blk_queue: short FIFO of whole 64-byte blocks between the byte front
// and the round engine. Depends on md5_pkg.
module md5_blk_queue
   import md5_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  md5_blk_type      push_entry,
   input  logic             pop,
   output md5_blk_type      pop_entry,
   output md5_q_status_type q_status
);

   md5_blk_type            mem_ff [MD5_Q_DEPTH];
   logic [MD5_Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [MD5_Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [MD5_Q_CNT_W-1:0] count_ff, count_in;

   assign q_status.full  = (count_ff == MD5_Q_CNT_W'(MD5_Q_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign pop_entry      = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      case ({push_valid, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push_valid && q_status.full && !pop))
      else $error("block pushed into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && q_status.empty))
      else $error("block popped from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MD5_Q_CNT_W'(MD5_Q_DEPTH))
      else $error("queue fill count beyond depth");

endmodule

### rtl/md5_round_engine.sv
// md5_round_engine: runs the 64 MD5 rounds of each queued block, one round a
// cycle, keeps the chaining words and sends the digest. Depends on md5_pkg,
// md5_rsp_if.
module md5_round_engine
   import md5_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  md5_q_status_type q_status,
   input  md5_blk_type      pop_entry,
   output logic             pop,
   md5_rsp_if.source        rsp_chan
);

   typedef enum logic [2:0] {ST_IDLE, ST_PREP, ST_ROUND, ST_ADD, ST_EMIT} state_type;

   state_type         state_ff, state_in;
   logic [5:0]        round_ff, round_in;
   logic [31:0]       a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic [31:0]       pre_ff, pre_in;
   md5_words_type     msg_ff, msg_in;
   logic              last_ff, last_in;
   logic [3:0][31:0]  chain_ff, chain_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       word_ff, word_in;
   logic [1:0]        idx_ff, idx_in;

   logic              rsp_take;
   logic [5:0]        round_nxt;
   logic [1:0]        idx_nxt;
   logic [31:0]       f_val;
   logic [31:0]       t_val;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.digest_word = word_ff;
   assign rsp_chan.word_index  = idx_ff;
   assign rsp_chan.last_word   = (idx_ff == MD5_LAST_WORD);
   assign rsp_take             = rsp_valid_ff && rsp_chan.ready;

   assign round_nxt = round_ff + 6'd1;
   assign idx_nxt   = idx_ff + 2'd1;
   assign f_val     = md5_f(round_ff[5:4], b_ff, c_ff, d_ff);
   assign t_val     = f_val + pre_ff;

   // Round sequencer; pre_ff holds a + K + M of the coming round
   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      pre_in       = pre_ff;
      msg_in       = msg_ff;
      last_in      = last_ff;
      chain_in     = chain_ff;
      rsp_valid_in = rsp_valid_ff;
      word_in      = word_ff;
      idx_in       = idx_ff;
      pop          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               msg_in   = pop_entry.words;
               last_in  = pop_entry.last_blk;
               a_in     = chain_ff[0];
               b_in     = chain_ff[1];
               c_in     = chain_ff[2];
               d_in     = chain_ff[3];
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            pre_in   = a_ff + md5_k(6'd0) + msg_ff[0];
            round_in = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            a_in     = d_ff;
            b_in     = b_ff + md5_rotl(t_val, md5_shift(round_ff));
            c_in     = b_ff;
            d_in     = c_ff;
            pre_in   = d_ff + md5_k(round_nxt) + msg_ff[md5_g(round_nxt)];
            round_in = round_nxt;
            if (round_ff == MD5_LAST_ROUND) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
            if (last_ff) begin
               rsp_valid_in = 1'b1;
               word_in      = chain_ff[0] + a_ff;
               idx_in       = '0;
               state_in     = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_take) begin
               if (idx_ff == MD5_LAST_WORD) begin
                  rsp_valid_in = 1'b0;
                  chain_in     = MD5_INIT;
                  state_in     = ST_IDLE;
               end else begin
                  idx_in  = idx_nxt;
                  word_in = chain_ff[idx_nxt];
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chain_ff     <= MD5_INIT;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         round_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         chain_ff     <= chain_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         round_ff     <= round_in;
      end
   end

   // Working variables and payload, no reset
   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      d_ff    <= d_in;
      pre_ff  <= pre_in;
      msg_ff  <= msg_in;
      last_ff <= last_in;
      word_ff <= word_in;
   end

   a_rsp_only_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_EMIT))
      else $error("digest word shown outside emit");

   a_add_after_rounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD) |-> ($past(state_ff) == ST_ROUND)
                               && ($past(round_ff) == MD5_LAST_ROUND))
      else $error("feed-forward add without all 64 rounds");

   a_chain_reinit: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && (idx_ff == MD5_LAST_WORD)) |=>
         (chain_ff == MD5_INIT) && (state_ff == ST_IDLE) && !rsp_valid_ff)
      else $error("chaining words not reinitialized after digest");

endmodule

### dv/testbench.sv
// Testbench for md5_message_digest: streams message bytes, checks digest words.
// Depends on md5_pkg, md5_req_if, md5_rsp_if and the md5_message_digest RTL.
`timescale 1ns / 100ps

module testbench
   import md5_pkg::*;
();

   localparam int IDLE_LIMIT  = 2000;
   localparam int TAIL_CYCLES = 300;
   localparam int WORD_TARGET = 200;

   // Bit-exact MD5 digest tracker: follows accepted bytes, queues due digest words
   class md5_digest_tracker;
      typedef struct packed {
         logic [31:0] value;
         logic [1:0]  index;
         logic        final_word;
      } digest_word_type;

      localparam bit [0:63][31:0] ROUND_ADD = {
         32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
         32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
         32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
         32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
         32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
         32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
         32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
         32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
         32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
         32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
         32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
         32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
         32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
         32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
         32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
         32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};

      localparam bit [0:15][4:0] ROUND_ROT = {
         5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
         5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};

      logic [31:0]     chain [4];
      logic [31:0]     block [16];
      logic [63:0]     bit_count;
      digest_word_type digest_due [$];
      int              errors;

      function new();
         errors = 0;
         restart();
      endfunction

      function void restart();
         chain[0] = 32'h67452301;
         chain[1] = 32'hefcdab89;
         chain[2] = 32'h98badcfe;
         chain[3] = 32'h10325476;
         foreach (block[w]) block[w] = '0;
         bit_count = '0;
      endfunction

      function int pending();
         return digest_due.size();
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("tb: mismatch on %s: got %h, want %h", what, got, want);
         errors++;
      endtask

      function void put_byte(int pos, logic [7:0] value);
         block[pos / 4][(pos % 4) * 8 +: 8] = value;
      endfunction

      // 64 rounds over the buffered block, then feed-forward into the chain
      function void compress();
         logic [31:0] a, b, c, d, f, t;
         int          i, g, grp, sh;
         a = chain[0];
         b = chain[1];
         c = chain[2];
         d = chain[3];
         for (i = 0; i < 64; i++) begin
            grp = i / 16;
            case (grp)
               0: begin
                  f = (b & c) | (~b & d);
                  g = i;
               end
               1: begin
                  f = (b & d) | (c & ~d);
                  g = (5 * i + 1) % 16;
               end
               2: begin
                  f = b ^ c ^ d;
                  g = (3 * i + 5) % 16;
               end
               default: begin
                  f = c ^ (b | ~d);
                  g = (7 * i) % 16;
               end
            endcase
            t = a + f + ROUND_ADD[i] + block[g];
            sh = int'(ROUND_ROT[grp * 4 + i % 4]);
            a = d;
            d = c;
            c = b;
            b = b + ((t << sh) | (t >> (32 - sh)));
         end
         chain[0] += a;
         chain[1] += b;
         chain[2] += c;
         chain[3] += d;
      endfunction

      // One accepted request word: absorb the byte, on message end pad and queue digest
      function void take_word(logic [7:0] data, logic has_byte, logic ends_msg);
         int              pos, k;
         logic [63:0]     msg_len;
         digest_word_type entry;
         if (has_byte) begin
            pos = int'(bit_count[8:3]);
            put_byte(pos, data);
            bit_count += 64'd8;
            if (pos == 63) compress();
         end
         if (!ends_msg) return;

         msg_len = bit_count;
         pos = int'(bit_count[8:3]);
         put_byte(pos, 8'h80);
         for (k = pos + 1; k < 64; k++) put_byte(k, 8'h00);
         // length does not fit behind the pad byte: one extra block, zero apart from the length
         if (pos >= 56) begin
            compress();
            foreach (block[w]) block[w] = '0;
         end
         block[14] = msg_len[31:0];
         block[15] = msg_len[63:32];
         compress();

         for (k = 0; k < 4; k++) begin
            entry.value      = chain[k];
            entry.index      = k[1:0];
            entry.final_word = (k[1:0] == MD5_LAST_WORD);
            digest_due.push_back(entry);
         end
         restart();
      endfunction

      task check_digest_word(logic [31:0] value, logic [1:0] index,
                             logic final_word);
         digest_word_type want;
         if (digest_due.size() == 0) begin
            report("unexpected digest word", value, '0);
            return;
         end
         want = digest_due.pop_front();
         if (value !== want.value) report("digest_word", value, want.value);
         if (index !== want.index) report("word_index", 32'(index), 32'(want.index));
         if (final_word !== want.final_word)
            report("last_word", 32'(final_word), 32'(want.final_word));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   md5_req_if req_chan ();
   md5_rsp_if rsp_chan ();

   md5_message_digest u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   md5_digest_tracker tracker = new();

   int words_sent = 0;
   int idle_cycles = 0;
   bit send_burst = 1'b0;
   bit take_burst = 1'b0;

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: stop if no word moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Drive one request word after a random gap; returns once it is accepted
   task automatic send_word(input logic [7:0] data, input logic has_byte,
                            input logic ends_msg);
      int gap;
      if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
      gap = send_burst ? 0 : int'($urandom_range(0, 9));
      repeat (gap) @(negedge clock) req_chan.valid <= 1'b0;
      @(negedge clock);
      req_chan.valid      <= 1'b1;
      req_chan.data_byte  <= data;
      req_chan.byte_valid <= has_byte;
      req_chan.last_byte  <= ends_msg;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      tracker.take_word(data, has_byte, ends_msg);
      if (has_byte || ends_msg) words_sent++;
   endtask

   // Whole message with random bytes and occasional ignored words in between;
   // the end marker rides on the final byte or comes as a word of its own
   task automatic send_message(input int len, input bit tail_byte);
      int i;
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 7) == 0) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_word(8'($urandom_range(0, 255)), 1'b1, tail_byte && (i == len - 1));
      end
      if (!tail_byte || len == 0) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   // Digest side: random stall before each word, then check it
   initial begin
      int gap;
      forever begin
         if ($urandom_range(0, 15) == 0) take_burst = !take_burst;
         gap = take_burst ? 0 : int'($urandom_range(0, 9));
         repeat (gap) @(negedge clock) rsp_chan.ready <= 1'b0;
         @(negedge clock) rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         tracker.check_digest_word(rsp_chan.digest_word, rsp_chan.word_index,
                                   rsp_chan.last_word);
      end
   end

   // Main sequence
   initial begin
      int msgs, len;
      int long_lens [3];
      int odd_lens [9];
      long_lens = '{56, 63, 64};
      odd_lens  = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.data_byte  <= 8'h00;
      req_chan.byte_valid <= 1'b0;
      req_chan.last_byte  <= 1'b0;
      rsp_chan.ready      <= 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed: empty message
      send_word(8'h00, 1'b0, 1'b1);
      // "abc", end marker on the final byte
      send_word(8'h61, 1'b1, 1'b0);
      send_word(8'h62, 1'b1, 1'b0);
      send_word(8'h63, 1'b1, 1'b1);
      // byte extremes, ignored words carrying data, end word without a byte
      send_word(8'hff, 1'b0, 1'b0);
      send_word(8'h00, 1'b1, 1'b0);
      send_word(8'hff, 1'b1, 1'b0);
      send_word(8'ha5, 1'b0, 1'b0);
      send_word(8'h5a, 1'b0, 1'b1);
      // single byte, end on a valid byte
      send_word(8'hff, 1'b1, 1'b1);
      // pad byte value as data, then ignored word, then empty end
      send_word(8'h80, 1'b1, 1'b0);
      send_word(8'h7f, 1'b0, 1'b0);
      send_word(8'h01, 1'b0, 1'b1);

      // Random messages; the first few cross block and length-tail boundaries
      msgs = 0;
      while (words_sent < WORD_TARGET) begin
         if (msgs < 3)
            len = long_lens[msgs];
         else if ($urandom_range(0, 3) == 0)
            len = odd_lens[$urandom_range(0, 8)];
         else
            len = int'($urandom_range(0, 20));
         send_message(len, 1'($urandom_range(0, 1)));
         msgs++;
      end
      @(negedge clock) req_chan.valid <= 1'b0;

      while (tracker.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

### sim.f
rtl/md5_pkg.sv
rtl/md5_req_if.sv
rtl/md5_rsp_if.sv
rtl/md5_msg_front.sv
rtl/md5_blk_queue.sv
rtl/md5_round_engine.sv
rtl/md5_message_digest.sv
dv/testbench.sv
